### hw/rtl/lisr_pkg.sv
// ----------------------------------------------------------------------------
// lisr_pkg
// Shared widths, word types and divider request/response types for the
// linear interpolation slice resampler.
// ----------------------------------------------------------------------------
package lisr_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int POS_W           = 16;
  localparam int START_W         = 24;
  localparam int COUNT_W         = 16;
  localparam int RATE_W          = 17;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 24;
  localparam int MAX_RUN_DEF     = 64;
  localparam int INDEX_WIDTH_DEF = 24;
  localparam int MUL_W           = 18;
  localparam int DIV_NUM_W       = 34;
  localparam int DIV_DEN_W       = 18;
  localparam int DIV_Q_W         = 16;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;
  } src_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] pcm;
    logic [POS_W-1:0]           out_position;
    logic                       last_of_run;
    logic                       slice_done;
    logic                       overrun;
  } res_word_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic                 ovf;
    logic [DIV_Q_W-1:0]   quotient;
    logic [DIV_DEN_W-1:0] remainder;
  } div_rsp_t;

endpackage

### hw/rtl/lisr_div.sv
// ----------------------------------------------------------------------------
// lisr_div
// Restoring divider, one quotient bit per cycle, sixteen quotient bits.
// Flags overflow when the quotient does not fit.
// ----------------------------------------------------------------------------
module lisr_div (
  input  logic               clk,
  input  logic               rst,
  input  lisr_pkg::div_req_t req,
  output lisr_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(lisr_pkg::DIV_Q_W + 1);

  logic [lisr_pkg::DIV_DEN_W-1:0] rem;
  logic [lisr_pkg::DIV_DEN_W-1:0] den;
  logic [lisr_pkg::DIV_Q_W-1:0]   shreg;
  logic [lisr_pkg::DIV_Q_W-1:0]   quo;
  logic [CNT_W-1:0]               cnt;
  logic                           done;
  logic                           ovf;
  logic [lisr_pkg::DIV_DEN_W:0]   trial_in;
  logic [lisr_pkg::DIV_DEN_W:0]   diff;
  logic                           fits;

  assign trial_in = {rem, shreg[lisr_pkg::DIV_Q_W-1]};
  assign diff     = trial_in - {1'b0, den};
  assign fits     = (trial_in >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= CNT_W'(lisr_pkg::DIV_Q_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= req.dividend[lisr_pkg::DIV_NUM_W-1:lisr_pkg::DIV_Q_W];
      shreg <= req.dividend[lisr_pkg::DIV_Q_W-1:0];
      den   <= req.divisor;
      ovf   <= (req.dividend[lisr_pkg::DIV_NUM_W-1:lisr_pkg::DIV_Q_W] >= req.divisor);
    end else if (cnt != '0) begin
      rem   <= fits ? diff[lisr_pkg::DIV_DEN_W-1:0] : trial_in[lisr_pkg::DIV_DEN_W-1:0];
      quo   <= {quo[lisr_pkg::DIV_Q_W-2:0], fits};
      shreg <= {shreg[lisr_pkg::DIV_Q_W-2:0], 1'b0};
    end
  end

  assign rsp.done      = done;
  assign rsp.ovf       = ovf;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

### hw/rtl/linear_interp_slice_resampler_unit.sv
// A restart word runs the rate multiply and a divider pass, and emits nothing.
// Each output takes three multiply steps, a pass of the shared 16-step
// divider for interpolation and, unless the slice ends, one for the position
// advance. Buffered results leave after the run ends, stalling on res_ready.
// Reset is synchronous and restores config and control state, not the datapath.
// ----------------------------------------------------------------------------
// linear_interp_slice_resampler_unit
// Linear interpolation resampler over one slice of a source stream, built
// around one multiplier, one iterative divider and a small sequencer.
// ----------------------------------------------------------------------------
module linear_interp_slice_resampler_unit #(
  parameter int MAX_RUN     = lisr_pkg::MAX_RUN_DEF,
  parameter int INDEX_WIDTH = lisr_pkg::INDEX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lisr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lisr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                src_valid,
  output logic                                src_ready,
  input  lisr_pkg::src_word_t                 src_word,
  output logic                                res_valid,
  input  logic                                res_ready,
  output lisr_pkg::res_word_t                 res_word
);

  localparam int NW = $clog2(MAX_RUN + 1);
  localparam int AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam int CW = (INDEX_WIDTH > lisr_pkg::START_W) ? INDEX_WIDTH : lisr_pkg::START_W;
  localparam logic [CW:0]   IDX_MASK_X = ((CW+1)'(1) << INDEX_WIDTH) - (CW+1)'(1);
  localparam logic [NW-1:0] RUN_FULL   = NW'(MAX_RUN);
  localparam logic [15:0]   TOTAL_CAP  = 16'd65534;
  localparam logic [15:0]   PCM_MAX    = 16'd32767;

  localparam logic [lisr_pkg::CFG_INDEX_W-1:0] CFG_START_FRAME   = 3'd0;
  localparam logic [lisr_pkg::CFG_INDEX_W-1:0] CFG_SOURCE_COUNT  = 3'd1;
  localparam logic [lisr_pkg::CFG_INDEX_W-1:0] CFG_TARGET_FRAMES = 3'd2;
  localparam logic [lisr_pkg::CFG_INDEX_W-1:0] CFG_TARGET_RATE   = 3'd3;
  localparam logic [lisr_pkg::CFG_INDEX_W-1:0] CFG_SOURCE_RATE   = 3'd4;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RMUL  = 4'd1;
  localparam logic [3:0] S_RDIV  = 4'd2;
  localparam logic [3:0] S_RWAIT = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_MUL1  = 4'd5;
  localparam logic [3:0] S_MUL2  = 4'd6;
  localparam logic [3:0] S_MUL3  = 4'd7;
  localparam logic [3:0] S_IGO   = 4'd8;
  localparam logic [3:0] S_IWAIT = 4'd9;
  localparam logic [3:0] S_STEP  = 4'd10;
  localparam logic [3:0] S_PWAIT = 4'd11;
  localparam logic [3:0] S_RD    = 4'd12;
  localparam logic [3:0] S_LOAD  = 4'd13;

  logic [lisr_pkg::START_W-1:0] start_frame;
  logic [lisr_pkg::COUNT_W-1:0] source_count;
  logic [lisr_pkg::COUNT_W-1:0] target_frames;
  logic [lisr_pkg::RATE_W-1:0]  target_rate;
  logic [lisr_pkg::RATE_W-1:0]  source_rate;

  logic [3:0]                   state;
  logic signed [15:0]           prev_sample;
  logic signed [15:0]           cur_sample;
  logic [INDEX_WIDTH-1:0]       source_index;
  logic [INDEX_WIDTH-1:0]       left_index;
  logic [INDEX_WIDTH-1:0]       nlp;
  logic [15:0]                  out_counter;
  logic [15:0]                  phase_remainder;
  logic [15:0]                  output_total;
  logic                         slice_finished;
  logic [NW-1:0]                nres;
  logic                         over;
  logic                         done_here;
  logic [AW-1:0]                rd;

  logic signed [lisr_pkg::MUL_W-1:0]   mul_a;
  logic signed [lisr_pkg::MUL_W-1:0]   mul_b;
  logic signed [2*lisr_pkg::MUL_W-1:0] mul_p;
  logic signed [2*lisr_pkg::MUL_W-1:0] mul_q;
  logic signed [2*lisr_pkg::MUL_W-1:0] acc;
  logic signed [2*lisr_pkg::MUL_W-1:0] acc_sum;
  logic signed [32:0]                  num;
  logic [32:0]                         num_mag;

  logic [31:0] mem [MAX_RUN];
  logic [31:0] mem_q;

  lisr_pkg::div_req_t div_req;
  lisr_pkg::div_rsp_t div_rsp;

  logic [15:0]            tf_eff;
  logic [16:0]            sr_eff;
  logic [15:0]            sc_eff;
  logic [15:0]            cnt_minus_rem;
  logic [16:0]            pos_sum;
  logic                   step_end;
  logic [16:0]            q_even;
  logic [15:0]            total_next;
  logic [15:0]            pcm_val;
  logic [INDEX_WIDTH:0]   pos_x;
  logic [INDEX_WIDTH-1:0] pos_next;
  logic [CW-1:0]          start_x;
  logic [INDEX_WIDTH-1:0] restart_pos;
  logic                   src_take;
  logic                   rd_last;
  logic                   res_load;
  logic                   mem_we;

  lisr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cfg_ready = 1'b1;
  assign src_ready = (state == S_IDLE);
  assign src_take  = src_valid && src_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_frame   <= '0;
      source_count  <= 16'd1;
      target_frames <= 16'd1;
      target_rate   <= 17'd18500;
      source_rate   <= 17'd44100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_FRAME:   start_frame   <= cfg_data;
        CFG_SOURCE_COUNT:  source_count  <= cfg_data[15:0];
        CFG_TARGET_FRAMES: target_frames <= cfg_data[15:0];
        CFG_TARGET_RATE:   target_rate   <= cfg_data[16:0];
        CFG_SOURCE_RATE:   source_rate   <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  assign tf_eff        = (target_frames == '0) ? 16'd1 : target_frames;
  assign sr_eff        = (source_rate == '0) ? 17'd1 : source_rate;
  assign sc_eff        = (source_count == '0) ? 16'd1 : source_count;
  assign cnt_minus_rem = output_total - phase_remainder;
  assign pos_sum       = {1'b0, phase_remainder} + {1'b0, sc_eff};
  assign step_end      = (({1'b0, out_counter} + 17'd1) >= {1'b0, output_total});

  always_comb begin
    if (state == S_RMUL) begin
      mul_a = {2'b00, tf_eff};
      mul_b = {1'b0, target_rate};
    end else if (state == S_MUL1) begin
      mul_a = {{2{prev_sample[15]}}, prev_sample};
      mul_b = {2'b00, cnt_minus_rem};
    end else begin
      mul_a = {{2{cur_sample[15]}}, cur_sample};
      mul_b = {2'b00, phase_remainder};
    end
  end

  assign mul_p   = mul_a * mul_b;
  assign acc_sum = acc + mul_q;
  assign num_mag = num[32] ? $unsigned(-num) : $unsigned(num);

  always_comb begin
    div_req.start = (state == S_RDIV) || (state == S_IGO) || ((state == S_STEP) && !step_end);
    if (state == S_RDIV) begin
      div_req.dividend = {mul_q[32:0], 1'b0} + {17'd0, sr_eff};
      div_req.divisor  = {sr_eff, 1'b0};
    end else if (state == S_IGO) begin
      div_req.dividend = {num_mag, 1'b0} + {18'd0, output_total};
      div_req.divisor  = {1'b0, output_total, 1'b0};
    end else begin
      div_req.dividend = {17'd0, pos_sum};
      div_req.divisor  = {2'b00, output_total};
    end
  end

  assign q_even = {1'b0, div_rsp.quotient} + {16'd0, div_rsp.quotient[0]};

  always_comb begin
    if (div_rsp.ovf) begin
      total_next = TOTAL_CAP;
    end else if (div_rsp.quotient == '0) begin
      total_next = 16'd2;
    end else if (q_even > {1'b0, TOTAL_CAP}) begin
      total_next = TOTAL_CAP;
    end else begin
      total_next = q_even[15:0];
    end
  end

  always_comb begin
    if (num[32]) begin
      pcm_val = 16'd0 - div_rsp.quotient;
    end else if (div_rsp.quotient > PCM_MAX) begin
      pcm_val = PCM_MAX;
    end else begin
      pcm_val = div_rsp.quotient;
    end
  end

  assign pos_x       = {1'b0, nlp} + (INDEX_WIDTH+1)'(div_rsp.quotient);
  assign pos_next    = pos_x[INDEX_WIDTH] ? '1 : pos_x[INDEX_WIDTH-1:0];
  assign start_x     = CW'(start_frame);
  assign restart_pos = ({1'b0, start_x} > IDX_MASK_X) ? '1 : start_x[INDEX_WIDTH-1:0];

  assign rd_last  = ((NW'(rd) + NW'(1)) == nres);
  assign res_load = (state == S_LOAD) && (!res_valid || res_ready);
  assign mem_we   = (state == S_IWAIT) && div_rsp.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      prev_sample     <= '0;
      source_index    <= '0;
      out_counter     <= '0;
      phase_remainder <= '0;
      nlp             <= '0;
      output_total    <= 16'd1;
      slice_finished  <= 1'b1;
      nres            <= '0;
      over            <= 1'b0;
      done_here       <= 1'b0;
      rd              <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (src_take) begin
            if (src_word.restart) begin
              prev_sample <= src_word.sample;
              state       <= S_RMUL;
            end else if (source_index != '1) begin
              source_index <= source_index + 1'b1;
              nres         <= '0;
              over         <= 1'b0;
              done_here    <= 1'b0;
              state        <= S_CHECK;
            end else begin
              prev_sample <= src_word.sample;
            end
          end
        end
        S_RMUL:  state <= S_RDIV;
        S_RDIV:  state <= S_RWAIT;
        S_RWAIT: begin
          if (div_rsp.done) begin
            output_total    <= total_next;
            source_index    <= '0;
            out_counter     <= '0;
            phase_remainder <= '0;
            nlp             <= restart_pos;
            slice_finished  <= 1'b0;
            state           <= S_IDLE;
          end
        end
        S_CHECK: begin
          if (!slice_finished && (nlp == left_index)) begin
            if (nres == RUN_FULL) begin
              over  <= 1'b1;
              state <= S_STEP;
            end else begin
              state <= S_MUL1;
            end
          end else begin
            prev_sample <= cur_sample;
            rd          <= '0;
            state       <= (nres == '0) ? S_IDLE : S_RD;
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_MUL3;
        S_MUL3: state <= S_IGO;
        S_IGO:  state <= S_IWAIT;
        S_IWAIT: begin
          if (div_rsp.done) begin
            nres  <= nres + 1'b1;
            state <= S_STEP;
          end
        end
        S_STEP: begin
          out_counter <= out_counter + 1'b1;
          if (step_end) begin
            slice_finished <= 1'b1;
            done_here      <= 1'b1;
            state          <= S_CHECK;
          end else begin
            state <= S_PWAIT;
          end
        end
        S_PWAIT: begin
          if (div_rsp.done) begin
            phase_remainder <= div_rsp.remainder[15:0];
            nlp             <= pos_next;
            state           <= S_CHECK;
          end
        end
        S_RD: state <= S_LOAD;
        S_LOAD: begin
          if (res_load) begin
            rd    <= rd + 1'b1;
            state <= rd_last ? S_IDLE : S_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (src_take) begin
      cur_sample <= src_word.sample;
      left_index <= source_index;
    end
    if ((state == S_RMUL) || (state == S_MUL1) || (state == S_MUL2)) begin
      mul_q <= mul_p;
    end
    if (state == S_MUL2) begin
      acc <= mul_q;
    end
    if (state == S_MUL3) begin
      num <= acc_sum[32:0];
    end
    if (res_load) begin
      res_word.pcm          <= mem_q[31:16];
      res_word.out_position <= mem_q[15:0];
      res_word.last_of_run  <= rd_last;
      res_word.slice_done   <= rd_last && done_here;
      res_word.overrun      <= over;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[nres[AW-1:0]] <= {pcm_val, out_counter};
    end
    if (state == S_RD) begin
      mem_q <= mem[rd];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  a_mem_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (nres < RUN_FULL))
    else $error("result buffer write beyond its depth");

  a_over_full: assert property (@(posedge clk) disable iff (rst)
    over |-> (nres == RUN_FULL))
    else $error("overrun flagged with result buffer not full");

  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (phase_remainder < output_total))
    else $error("phase remainder not below output total");

  a_total_even: assert property (@(posedge clk) disable iff (rst)
    !slice_finished |-> (!output_total[0] && (output_total >= 16'd2)))
    else $error("active slice with odd or short output total");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_word.slice_done) |-> res_word.last_of_run)
    else $error("slice end marked on a word that does not close its run");

endmodule
